// File: hw/rtl/gregorian_to_lunar_date_top_macros.svh
// Assertion macros shared by the Gregorian to lunar date converter.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef GREGORIAN_TO_LUNAR_DATE_TOP_MACROS_SVH
`define GREGORIAN_TO_LUNAR_DATE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define G2L_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define G2L_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

// File: hw/rtl/g2l_pkg.sv
`default_nettype none
// Package for the Gregorian to lunar date converter: request and response
// types, sequencer states and the fixed calendar tables. No dependencies.
package g2l_pkg;

    localparam int TABLE_YEARS      = 73;
    localparam int TERM_YEARS       = 69;
    localparam int INFO_W           = 10;
    localparam logic [11:0] FIRST_YEAR      = 12'd1968;
    localparam logic [11:0] FIRST_REQ_YEAR  = 12'd1969;
    localparam logic [11:0] LAST_REQ_YEAR   = 12'd2039;
    localparam logic [11:0] TERM_FIRST_YEAR = 12'd1970;
    localparam logic [11:0] TERM_END_YEAR   = 12'd2039;
    localparam logic [19:0] SHORT_YEAR_LIMIT = 20'd4095;

    typedef struct packed {
        logic [11:0] greg_year;
        logic [3:0]  greg_month;
        logic [4:0]  greg_day;
    } g2l_req_t;

    typedef struct packed {
        logic        valid_res;
        logic [10:0] lunar_year;
        logic [3:0]  lunar_month;
        logic        leap_month;
        logic [4:0]  lunar_day;
        logic [3:0]  stem_index;
        logic [3:0]  branch_index;
        logic [4:0]  solar_term;
        logic [3:0]  holiday_code;
        logic [3:0]  festival_code;
    } g2l_rsp_t;

    typedef struct packed {
        logic              fit;
        logic [INFO_W-1:0] rest;
    } g2l_step_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LOAD,
        ST_WALK,
        ST_FINISH,
        ST_DONE
    } g2l_state_t;

    localparam logic [7:0] SPRING [TABLE_YEARS] = '{
        8'd130, 8'd217, 8'd206,
        8'd127, 8'd215, 8'd203, 8'd123, 8'd211, 8'd131, 8'd218, 8'd207, 8'd128, 8'd216,
        8'd205, 8'd125, 8'd213, 8'd202, 8'd220, 8'd209, 8'd219, 8'd217, 8'd206, 8'd127,
        8'd215, 8'd204, 8'd123, 8'd210, 8'd131, 8'd219, 8'd207, 8'd128, 8'd216, 8'd205,
        8'd124, 8'd212, 8'd201, 8'd122, 8'd209, 8'd129, 8'd218, 8'd207, 8'd126, 8'd214,
        8'd203, 8'd123, 8'd210, 8'd131, 8'd219, 8'd208, 8'd128, 8'd216, 8'd205, 8'd125,
        8'd212, 8'd201, 8'd122, 8'd210, 8'd129, 8'd217, 8'd206, 8'd126, 8'd213, 8'd203,
        8'd123, 8'd211, 8'd131, 8'd219, 8'd208, 8'd128, 8'd215, 8'd204, 8'd124, 8'd212
    };

    localparam logic [19:0] MONTH_BITS [TABLE_YEARS] = '{
        20'd461653, 20'd1386, 20'd2413,
        20'd330077, 20'd1197, 20'd2637, 20'd268877, 20'd3365, 20'd531109, 20'd2900,
        20'd2922, 20'd398042, 20'd2395,
        20'd1179, 20'd267415, 20'd2635, 20'd661067, 20'd1701, 20'd1748, 20'd398772,
        20'd2742, 20'd2391, 20'd330031,
        20'd1175, 20'd1611, 20'd200010, 20'd3749, 20'd527717, 20'd1452, 20'd2742,
        20'd332397, 20'd2350, 20'd3222,
        20'd268949, 20'd3402, 20'd3493, 20'd133973, 20'd1386, 20'd464219, 20'd605,
        20'd2349, 20'd334123, 20'd2709,
        20'd2890, 20'd267946, 20'd2773, 20'd592565, 20'd1210, 20'd2651, 20'd395863,
        20'd1323, 20'd2707, 20'd265877,
        20'd1706, 20'd2773, 20'd133557, 20'd1206, 20'd398510, 20'd2638, 20'd3366,
        20'd335142, 20'd3411, 20'd1450,
        20'd200042, 20'd2413, 20'd723293, 20'd1197, 20'd2637, 20'd399947, 20'd3365,
        20'd3410, 20'd334676, 20'd2906
    };

    // One row per year, first month in the top byte.
    localparam logic [95:0] TERM_ROWS [TERM_YEARS] = '{
        96'h95B496A5_96978878_78697887, 96'h96B496A6_97977879_79697877,
        96'h96A4A5A5_A6A68888_88788787, 96'hA5B596A5_A6968878_78788787,
        96'h95B496A5_96978878_78697887, 96'h96B496A6_97977879_78697877,
        96'h96A4A5B5_A6A68889_88788787, 96'hA5B496A5_96968888_78788787,
        96'h95B496A5_96978878_78797887, 96'h96B496A6_96977879_78697877,
        96'h96A4A5B5_A6A68888_88788787, 96'hA5B496A5_A6968888_78787787,
        96'h95B496A5_96978878_78797787, 96'h95B496A5_96977879_78697877,
        96'h96B4A5B5_A6A68788_88788787, 96'hA5B4A6A5_A6968888_78788787,
        96'hA5B496A5_96978878_78797787, 96'h95B496A5_96978879_78697887,
        96'h96B4A5B5_A6A68788_88788786, 96'hA5B4A5A5_A6968888_88788787,
        96'hA5B496A5_96968878_78797787, 96'h95B496A5_86978878_78697887,
        96'h96B4A5B5_A6A68788_88788786, 96'hA5B3A5A5_A6968888_88788787,
        96'hA5B496A5_96968878_78788787, 96'h95B496A5_96978876_78697887,
        96'h96B4A5B5_A6A68788_88788786, 96'hA5B3A5A5_A6A68888_88788787,
        96'hA5B496A5_96968878_78788787, 96'h95B496A5_96978878_78697887,
        96'h96B4A5B5_A6A68788_88788786, 96'hA5B3A5A5_A6A68888_88788787,
        96'hA5B496A5_96968878_78788787, 96'h95B496A5_96978878_78697887,
        96'h96B4A5B5_A6A68788_88788786, 96'hA5B3A5A5_A6A68888_88788787,
        96'hA5B496A5_A6968888_78788787, 96'h95B496A5_96978878_78697887,
        96'h96B4A5B5_A6A68788_87788786, 96'hA5B3A5B5_A6A68888_88788787,
        96'hA5B496A5_A6968888_78788787, 96'h95B496A5_96978878_78797887,
        96'h96B4A5B5_A5A68788_87788786, 96'hA5B3A5B5_A6A68788_88788787,
        96'hA5B496A5_A6968888_78788787, 96'h95B496A5_96978878_78797787,
        96'h95B4A5B4_A5A68788_87788786, 96'hA5C3A5B5_A6A68788_88788787,
        96'hA5B4A6A5_A6968888_78788787, 96'hA5B496A5_96968878_78797787,
        96'h95B4A5B4_A5A69787_87788786, 96'hA5C3A5B5_A6A68788_88788786,
        96'hA5B4A5A5_A6968888_88788787, 96'hA5B496A5_96968878_78797787,
        96'h95B4A5B4_A5A69787_87788796, 96'hA5C3A5B5_A6A68788_88788786,
        96'hA5B3A5A5_A6A68888_88788787, 96'hA5B496A5_96968878_78788787,
        96'h95B4A5B4_A5A69787_87788796, 96'hA5C3A5B5_A6A68788_88788786,
        96'hA5B3A5A5_A6A68888_88788787, 96'hA5B496A5_96968878_78788787,
        96'h95B4A5B4_A5A69787_87788796, 96'hA5C3A5B5_A6A68888_88788786,
        96'hA5B3A5A5_A6A68878_88788787, 96'hA5B496A5_A6968888_78788787,
        96'h95B4A5B4_A5A69787_87788796, 96'hA5C3A5B5_A6A68788_88788786,
        96'hA5B3A5A5_A6A68888_88788787
    };

    localparam logic [8:0] DAYS_BEFORE [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273,
        9'd304, 9'd334
    };

    localparam logic [11:0] HOLIDAY_KEYS [14] = '{
        12'h101, 12'h20E, 12'h308, 12'h30C, 12'h401, 12'h501, 12'h504,
        12'h601, 12'h701, 12'h801, 12'h90A, 12'hA01, 12'hC18, 12'hC19
    };

    localparam logic [11:0] FESTIVAL_KEYS [8] = '{
        12'h101, 12'h10F, 12'h202, 12'h505, 12'h707, 12'h80F, 12'h909, 12'hC08
    };

endpackage
`default_nettype wire

// File: hw/rtl/g2l_step_unit.sv
`default_nettype none
// Shared month step: compares the remaining day count with one month length
// and gives the count left after that month. Depends on g2l_pkg.
module g2l_step_unit (
    input  wire logic [g2l_pkg::INFO_W-1:0] info,
    input  wire logic                       month_long,
    output g2l_pkg::g2l_step_t              step
);

    logic [g2l_pkg::INFO_W-1:0] len;

    assign len       = g2l_pkg::INFO_W'(5'd29) + g2l_pkg::INFO_W'(month_long);
    assign step.fit  = (info <= len);
    assign step.rest = info - len;

endmodule
`default_nettype wire

// File: hw/rtl/g2l_lookup.sv
`default_nettype none
// Result assembly: month numbering with the leap mark, stem and branch,
// solar term, holiday and festival codes. Depends on g2l_pkg.
module g2l_lookup (
    input  wire logic [11:0]                greg_year,
    input  wire logic [3:0]                 greg_month,
    input  wire logic [4:0]                 greg_day,
    input  wire logic [6:0]                 idx,
    input  wire logic [19:0]                bits,
    input  wire logic                       k12,
    input  wire logic [3:0]                 n,
    input  wire logic [g2l_pkg::INFO_W-1:0] info,
    output g2l_pkg::g2l_rsp_t               rsp
);

    logic [3:0]  k;
    logic [3:0]  mon_raw;
    logic [3:0]  leapnum;
    logic [3:0]  mon;
    logic        leap;
    logic [7:0]  v10;
    logic [7:0]  v12;
    logic [15:0] p10;
    logic [15:0] p12;
    logic [7:0]  q10;
    logic [7:0]  q12;
    logic        in_term;
    logic [11:0] yr_off;
    logic [95:0] row;
    logic [3:0]  sel;
    logic [6:0]  shift;
    logic [7:0]  t;
    logic [4:0]  term;
    logic [11:0] hkey;
    logic [11:0] fkey;
    logic [3:0]  hcode;
    logic [3:0]  fcode;

    always_comb
    begin
        k       = k12 ? 4'd12 : 4'd11;
        mon_raw = k - n + 4'd1;
        leapnum = bits[19:16];
        mon     = mon_raw;
        leap    = 1'b0;
        if (k12)
        begin
            if (mon_raw == leapnum + 4'd1)
            begin
                mon  = mon_raw - 4'd1;
                leap = 1'b1;
            end
            else if (mon_raw > leapnum + 4'd1)
            begin
                mon = mon_raw - 4'd1;
            end
        end
    end

    // Year minus four, modulo 10 and 12, by reciprocal multiplication.
    always_comb
    begin
        v10 = {1'b0, idx} + 8'd4;
        v12 = {1'b0, idx} + 8'd8;
        p10 = 16'(v10) * 16'd205;
        p12 = 16'(v12) * 16'd171;
        q10 = 8'(p10 >> 11);
        q12 = 8'(p12 >> 11);
    end

    always_comb
    begin
        in_term = (greg_year >= g2l_pkg::TERM_FIRST_YEAR) &&
                  (greg_year < g2l_pkg::TERM_END_YEAR);
        yr_off  = greg_year - g2l_pkg::TERM_FIRST_YEAR;
        row     = g2l_pkg::TERM_ROWS[in_term ? yr_off[6:0] : 7'd0];
        sel     = 4'd12 - greg_month;
        shift   = {sel, 3'b000};
        t       = row[shift +: 8];
        term    = 5'd0;
        if (in_term)
        begin
            if (greg_day < 5'd15 && {1'b0, t[7:4]} == 5'd15 - greg_day)
                term = {greg_month, 1'b0} - 5'd1;
            else if (greg_day > 5'd15 && {1'b0, t[3:0]} == greg_day - 5'd15)
                term = {greg_month, 1'b0};
        end
    end

    always_comb
    begin
        hkey  = {greg_month, 3'b000, greg_day};
        fkey  = {mon, info[7:0]};
        hcode = 4'd0;
        fcode = 4'd0;
        for (int i = 13; i >= 0; i--)
        begin
            if (g2l_pkg::HOLIDAY_KEYS[i] == hkey)
                hcode = 4'(i + 1);
        end
        for (int i = 7; i >= 0; i--)
        begin
            if (g2l_pkg::FESTIVAL_KEYS[i] == fkey)
                fcode = 4'(i + 1);
        end
    end

    always_comb
    begin
        rsp.valid_res     = 1'b1;
        rsp.lunar_year    = 11'(g2l_pkg::FIRST_YEAR) + 11'(idx);
        rsp.lunar_month   = mon;
        rsp.leap_month    = leap;
        rsp.lunar_day     = info[4:0];
        rsp.stem_index    = 4'(v10 - 8'(q10 * 8'd10));
        rsp.branch_index  = 4'(v12 - 8'(q12 * 8'd12));
        rsp.solar_term    = term;
        rsp.holiday_code  = hcode;
        rsp.festival_code = fcode;
    end

endmodule
`default_nettype wire

// File: hw/rtl/gregorian_to_lunar_date_top.sv
`default_nettype none
// Top level of the Gregorian to lunar date converter: sequencer and datapath.
// Depends on g2l_pkg, g2l_step_unit, g2l_lookup and the assertion macros.
//
// One request is taken at a time and yields one response. A request passes
// the setup state, a load state for each lunar table year visited, a walk
// state for each lunar month walked by the shared month step unit, the
// finish state that assembles the result and the done state that presents
// it; how many walk steps it takes is set by how many months lie between the
// spring festival and the date. A request out of range goes from setup
// straight to done. The block stalls new requests until the response has
// been taken, and it returns to idle after each response before the next
// request is accepted. Dates outside 1969 to 2039, months outside 1 to 12 and
// day 0 give an all-zero response with valid_res low.
`include "gregorian_to_lunar_date_top_macros.svh"

module gregorian_to_lunar_date_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire g2l_pkg::g2l_req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output g2l_pkg::g2l_rsp_t  rsp
);

    g2l_pkg::g2l_state_t state_reg, state_next;
    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [6:0]  idx_reg, idx_next;
    logic [g2l_pkg::INFO_W-1:0] info_reg, info_next;
    logic [19:0] bits_reg, bits_next;
    logic        k12_reg, k12_next;
    logic [3:0]  n_reg, n_next;
    logic        row2_reg, row2_next;
    g2l_pkg::g2l_rsp_t rsp_reg, rsp_next;

    g2l_pkg::g2l_step_t step;
    g2l_pkg::g2l_rsp_t  lookup_rsp;

    logic        req_ok;
    logic [11:0] yoff;
    logic [6:0]  idx_cur;
    logic [7:0]  sp_cur;
    logic [7:0]  sp_sel;
    logic [3:0]  smon_cur;
    logic [4:0]  sday_cur;
    logic        sp_sel_feb;
    logic [4:0]  sday_sel;
    logic        pre_spring;
    logic [6:0]  idx_sel;
    logic [10:0] info_calc;
    logic        walk_end;

    g2l_step_unit u_step (
        .info       (info_reg),
        .month_long (bits_reg[n_reg]),
        .step       (step)
    );

    g2l_lookup u_lookup (
        .greg_year  (year_reg),
        .greg_month (month_reg),
        .greg_day   (day_reg),
        .idx        (idx_reg),
        .bits       (bits_reg),
        .k12        (k12_reg),
        .n          (n_reg),
        .info       (info_reg),
        .rsp        (lookup_rsp)
    );

    always_comb
    begin
        req_ok = (year_reg >= g2l_pkg::FIRST_REQ_YEAR) &&
                 (year_reg <= g2l_pkg::LAST_REQ_YEAR) &&
                 (month_reg >= 4'd1) && (month_reg <= 4'd12) && (day_reg != 5'd0);
        yoff       = year_reg - g2l_pkg::FIRST_YEAR;
        idx_cur    = req_ok ? yoff[6:0] : 7'd1;
        sp_cur     = g2l_pkg::SPRING[idx_cur];
        smon_cur   = (sp_cur >= 8'd200) ? 4'd2 : 4'd1;
        sday_cur   = (sp_cur >= 8'd200) ? 5'(sp_cur - 8'd200) : 5'(sp_cur - 8'd100);
        pre_spring = (month_reg < smon_cur) ||
                     (month_reg == smon_cur && day_reg < sday_cur);
        idx_sel    = pre_spring ? idx_cur - 7'd1 : idx_cur;
        sp_sel     = g2l_pkg::SPRING[idx_sel];
        sp_sel_feb = (sp_sel >= 8'd200);
        sday_sel   = sp_sel_feb ? 5'(sp_sel - 8'd200) : 5'(sp_sel - 8'd100);
        info_calc  = 11'(day_reg) + 11'(g2l_pkg::DAYS_BEFORE[4'(month_reg - 4'd1)]) +
                     11'd1 - (sp_sel_feb ? 11'd31 : 11'd0) - 11'(sday_sel) +
                     (pre_spring ? 11'd365 : 11'd0) +
                     11'(year_reg[1:0] == 2'd0 && month_reg > 4'd2) +
                     11'(pre_spring && year_reg[1:0] == 2'd1);
        walk_end   = !step.fit && (n_reg == 4'd0) &&
                     (row2_reg || 32'(idx_reg) + 1 >= g2l_pkg::TABLE_YEARS);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            g2l_pkg::ST_IDLE:
                if (req_valid)
                    state_next = g2l_pkg::ST_SETUP;
            g2l_pkg::ST_SETUP:
                state_next = req_ok ? g2l_pkg::ST_LOAD : g2l_pkg::ST_DONE;
            g2l_pkg::ST_LOAD:
                state_next = g2l_pkg::ST_WALK;
            g2l_pkg::ST_WALK:
                if (step.fit)
                    state_next = g2l_pkg::ST_FINISH;
                else if (walk_end)
                    state_next = g2l_pkg::ST_DONE;
                else if (n_reg == 4'd0)
                    state_next = g2l_pkg::ST_LOAD;
            g2l_pkg::ST_FINISH:
                state_next = g2l_pkg::ST_DONE;
            g2l_pkg::ST_DONE:
                if (!rsp_stall)
                    state_next = g2l_pkg::ST_IDLE;
            default:
                state_next = g2l_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_stall = (state_reg != g2l_pkg::ST_IDLE);
        rsp_valid = (state_reg == g2l_pkg::ST_DONE);
        rsp       = rsp_reg;
    end

    always_comb
    begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        idx_next   = idx_reg;
        info_next  = info_reg;
        bits_next  = bits_reg;
        k12_next   = k12_reg;
        n_next     = n_reg;
        row2_next  = row2_reg;
        rsp_next   = rsp_reg;
        case (state_reg)
            g2l_pkg::ST_IDLE:
            begin
                year_next  = req.greg_year;
                month_next = req.greg_month;
                day_next   = req.greg_day;
            end
            g2l_pkg::ST_SETUP:
            begin
                idx_next  = idx_sel;
                info_next = info_calc[g2l_pkg::INFO_W-1:0];
                row2_next = 1'b0;
                rsp_next  = '0;
            end
            g2l_pkg::ST_LOAD:
            begin
                bits_next = g2l_pkg::MONTH_BITS[idx_reg];
                k12_next  = !(g2l_pkg::MONTH_BITS[idx_reg] < g2l_pkg::SHORT_YEAR_LIMIT);
                n_next    = (g2l_pkg::MONTH_BITS[idx_reg] < g2l_pkg::SHORT_YEAR_LIMIT) ?
                            4'd11 : 4'd12;
            end
            g2l_pkg::ST_WALK:
            begin
                if (!step.fit)
                begin
                    info_next = step.rest;
                    if (walk_end)
                    begin
                        rsp_next = '0;
                    end
                    else if (n_reg == 4'd0)
                    begin
                        row2_next = 1'b1;
                        idx_next  = idx_reg + 7'd1;
                    end
                    else
                    begin
                        n_next = n_reg - 4'd1;
                    end
                end
            end
            g2l_pkg::ST_FINISH:
                rsp_next = lookup_rsp;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= g2l_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        year_reg  <= year_next;
        month_reg <= month_next;
        day_reg   <= day_next;
        idx_reg   <= idx_next;
        info_reg  <= info_next;
        bits_reg  <= bits_next;
        k12_reg   <= k12_next;
        n_reg     <= n_next;
        row2_reg  <= row2_next;
        rsp_reg   <= rsp_next;
    end

    `G2L_ASSERT_NEXT(a_accept_to_setup, req_valid && !req_stall, state_reg == g2l_pkg::ST_SETUP)
    `G2L_ASSERT_SAME(a_busy_while_rsp, rsp_valid, req_stall)
    `G2L_ASSERT_SAME(a_valid_day_nonzero, rsp_valid && rsp.valid_res, rsp.lunar_day != 5'd0)
    `G2L_ASSERT_NEXT(a_fit_to_finish, state_reg == g2l_pkg::ST_WALK && step.fit,
                     state_reg == g2l_pkg::ST_FINISH)

endmodule
`default_nettype wire

// File: dv/tb_gregorian_to_lunar_date_top.sv
// Testbench for the Gregorian to lunar date converter: drives date requests,
// predicts each response from the g2l_pkg calendar tables and checks.
// Depends on g2l_pkg and the gregorian_to_lunar_date_top RTL.
class lunar_date_board;
    g2l_pkg::g2l_rsp_t pending[$];
    int errors;

    function int key_index(input logic [11:0] keys[], input logic [11:0] key);
        int hit;
        hit = 0;
        foreach (keys[i])
            if (hit == 0 && keys[i] == key)
                hit = i + 1;
        return hit;
    endfunction

    function int from_spring(input int row, input int mon, input int dy);
        int sp;
        sp = g2l_pkg::SPRING[row];
        return dy + g2l_pkg::DAYS_BEFORE[mon - 1] - 31 * (sp / 100 - 1) - sp % 100 + 1;
    endfunction

    function g2l_pkg::g2l_rsp_t convert(input g2l_pkg::g2l_req_t rq);
        g2l_pkg::g2l_rsp_t r;
        int yr, mo, dy, row, sp, left, width, n, len, mon, leapnum, lyr, t, pass;
        logic [19:0] bits;
        logic [95:0] trow;
        bit found;
        logic [11:0] hk[], fk[];
        r = '0;
        yr = rq.greg_year;
        mo = rq.greg_month;
        dy = rq.greg_day;
        found = 0;
        width = 0;
        n = 0;
        bits = '0;
        if (yr < 1969 || yr > 2039 || mo < 1 || mo > 12 || dy < 1)
            return r;
        row = yr - 1968;
        sp = g2l_pkg::SPRING[row];
        if (mo < sp / 100 || (mo == sp / 100 && dy < sp % 100)) begin
            row--;
            left = 365 + from_spring(row, mo, dy);
            if (yr % 4 == 0 && mo > 2)
                left++;
            if ((yr - 1) % 4 == 0)
                left++;
        end
        else begin
            left = from_spring(row, mo, dy);
            if (yr % 4 == 0 && mo > 2)
                left++;
        end
        for (pass = 0; pass < 2 && !found; pass++) begin
            if (row < 0 || row >= g2l_pkg::TABLE_YEARS)
                break;
            bits = g2l_pkg::MONTH_BITS[row];
            width = (bits < 4095) ? 11 : 12;
            for (n = width; n >= 0; n--) begin
                len = 29 + bits[n];
                if (left <= len) begin
                    found = 1;
                    break;
                end
                left -= len;
            end
            if (!found)
                row++;
        end
        if (!found)
            return r;
        lyr = 1968 + row;
        mon = width - n + 1;
        if (width == 12) begin
            leapnum = bits[19:16];
            if (mon == leapnum + 1) begin
                mon--;
                r.leap_month = 1'b1;
            end
            else if (mon > leapnum + 1)
                mon--;
        end
        if (yr >= 1970 && yr < 1970 + g2l_pkg::TERM_YEARS) begin
            trow = g2l_pkg::TERM_ROWS[yr - 1970];
            t = trow[95 - 8 * (mo - 1) -: 8];
            if (dy < 15 && (t >> 4) == 15 - dy)
                r.solar_term = 5'(2 * (mo - 1) + 1);
            else if (dy > 15 && (t & 15) == dy - 15)
                r.solar_term = 5'(2 * (mo - 1) + 2);
        end
        hk = new[14];
        fk = new[8];
        foreach (hk[i])
            hk[i] = g2l_pkg::HOLIDAY_KEYS[i];
        foreach (fk[i])
            fk[i] = g2l_pkg::FESTIVAL_KEYS[i];
        r.valid_res = 1'b1;
        r.lunar_year = 11'(lyr);
        r.lunar_month = 4'(mon);
        r.lunar_day = 5'(left);
        r.stem_index = 4'((lyr - 4) % 10);
        r.branch_index = 4'((lyr - 4) % 12);
        r.holiday_code = 4'(key_index(hk, {mo[3:0], 3'b000, dy[4:0]}));
        r.festival_code = 4'(key_index(fk, 12'((mon << 8) | left)));
        return r;
    endfunction

    function void note_request(input g2l_pkg::g2l_req_t rq);
        pending.push_back(convert(rq));
    endfunction

    task report(input string what);
        $display("MISMATCH %s", what);
        errors++;
    endtask

    task check_response(input g2l_pkg::g2l_rsp_t got);
        g2l_pkg::g2l_rsp_t e;
        if (pending.size() == 0) begin
            report($sformatf("unexpected response %h", got));
            return;
        end
        e = pending.pop_front();
        if (got.valid_res !== e.valid_res) report("valid_res");
        if (got.lunar_year !== e.lunar_year) report("lunar_year");
        if (got.lunar_month !== e.lunar_month) report("lunar_month");
        if (got.leap_month !== e.leap_month) report("leap_month");
        if (got.lunar_day !== e.lunar_day) report("lunar_day");
        if (got.stem_index !== e.stem_index) report("stem_index");
        if (got.branch_index !== e.branch_index) report("branch_index");
        if (got.solar_term !== e.solar_term) report("solar_term");
        if (got.holiday_code !== e.holiday_code) report("holiday_code");
        if (got.festival_code !== e.festival_code) report("festival_code");
    endtask
endclass

module tb_gregorian_to_lunar_date_top;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    g2l_pkg::g2l_req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    g2l_pkg::g2l_rsp_t rsp;

    lunar_date_board board = new();
    int idle_cycles = 0;

    gregorian_to_lunar_date_top dut (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_stall(req_stall),
        .req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_date(input g2l_pkg::g2l_req_t rq);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req <= rq;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        board.note_request(rq);
        @(negedge clk);
    endtask

    task automatic send_fields(input int y, input int m, input int d);
        g2l_pkg::g2l_req_t rq;
        rq.greg_year = 12'(y);
        rq.greg_month = 4'(m);
        rq.greg_day = 5'(d);
        send_date(rq);
    endtask

    always @(posedge clk) begin
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_response(rsp);
        if (rst_n && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > 2000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int len;
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 3) == 0) begin
                len = gap_length();
                rsp_stall <= 1'b1;
                repeat (len + 1) @(negedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    initial begin
        int kind;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_fields(1969, 1, 1);
        send_fields(2039, 12, 31);
        send_fields(1968, 6, 1);
        send_fields(2040, 6, 1);
        send_fields(0, 0, 0);
        send_fields(4095, 15, 31);
        send_fields(2000, 0, 10);
        send_fields(2000, 13, 10);
        send_fields(2000, 5, 0);
        send_fields(1969, 2, 31);
        send_fields(1969, 3, 21);
        send_fields(2039, 12, 22);
        send_fields(2020, 1, 24);
        send_fields(2020, 1, 25);
        send_fields(2020, 5, 23);
        send_fields(2020, 6, 25);
        send_fields(2023, 3, 22);
        send_fields(2024, 2, 29);
        send_fields(2017, 8, 28);
        send_fields(2023, 4, 5);
        send_fields(2012, 12, 25);
        send_fields(1984, 10, 1);
        repeat (600) begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                send_fields($urandom_range(0, 4095), $urandom_range(0, 15),
                            $urandom_range(0, 31));
            else if (kind == 1)
                send_fields($urandom_range(1969, 2039), $urandom_range(1, 12),
                            $urandom_range(0, 31));
            else
                send_fields($urandom_range(1969, 2039), $urandom_range(1, 12),
                            $urandom_range(1, 28));
        end
        req_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
